// File: design/utf8d_pkg.sv
// types, constants and the lead byte decode shared by the utf-8 decoder
package utf8d_pkg;

   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned CP_W     = 32;
   localparam int unsigned TRAIL_W  = 3;
   localparam int unsigned PAYLD_W  = 6;

   typedef logic [BYTE_W-1:0]  byte_type;
   typedef logic [CP_W-1:0]    cp_type;
   typedef logic [TRAIL_W-1:0] trail_type;

   typedef struct packed {
      logic      emit;
      trail_type trail_left;
      cp_type    acc;
   } step_type;

   // trail bytes announced by a lead byte
   function automatic trail_type trail_count(input byte_type b);
      trail_type n;
      priority if (b < 8'hC0) n = 3'd0;
      else if (b < 8'hE0)     n = 3'd1;
      else if (b < 8'hF0)     n = 3'd2;
      else if (b < 8'hF8)     n = 3'd3;
      else if (b < 8'hFC)     n = 3'd4;
      else                    n = 3'd5;
      return n;
   endfunction

   // low 7-n bits of the lead byte
   function automatic byte_type lead_mask(input trail_type n);
      byte_type m;
      m = 8'hFF >> (3'd1 + n);
      return m;
   endfunction

endpackage

// File: design/utf8d_step.sv
// next decoder state and result for one byte
module utf8d_step (
   input  utf8d_pkg::byte_type  in_byte,
   input  utf8d_pkg::cp_type    acc,
   input  utf8d_pkg::trail_type trail_left,
   output utf8d_pkg::step_type  step
);

   utf8d_pkg::trail_type n;

   assign n = utf8d_pkg::trail_count(in_byte);

   always_comb begin
      if (trail_left == 3'd0) begin
         step.acc        = {24'd0, in_byte & utf8d_pkg::lead_mask(n)};
         step.trail_left = n;
         step.emit       = (n == 3'd0);
      end else begin
         step.acc        = {acc[utf8d_pkg::CP_W-utf8d_pkg::PAYLD_W-1:0],
                            in_byte[utf8d_pkg::PAYLD_W-1:0]};
         step.trail_left = trail_left - 3'd1;
         step.emit       = (trail_left == 3'd1);
      end
   end

endmodule

// File: design/utf8_stream_decoder.sv
// utf-8 stream decoder (six byte form), one byte per transfer
//
//   channel  ports                          width  direction
//   req      req_valid req_ready req_in_byte    8  in
//   rsp      rsp_valid rsp_ready rsp_code_point 32 out
//
// a byte is taken every cycle unless a stall on rsp holds it in the input register,
// and its code point, if it completes one, is then written to the result register
// bytes that open or continue a sequence pass through without a result
// reset drops a partly received sequence and any pending transfer
// a stall on rsp holds the input register only when its byte would emit
module utf8_stream_decoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_in_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_code_point
);

   logic                 in_valid_ff;
   utf8d_pkg::byte_type  in_byte_ff;
   utf8d_pkg::cp_type    acc_ff;
   utf8d_pkg::trail_type trail_ff;
   logic                 out_valid_ff;
   utf8d_pkg::cp_type    out_cp_ff;

   utf8d_pkg::step_type  step;
   logic                 out_free;
   logic                 advance;

   utf8d_step u_step (
      .in_byte    (in_byte_ff),
      .acc        (acc_ff),
      .trail_left (trail_ff),
      .step       (step)
   );

   assign out_free  = !out_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && (!step.emit || out_free);
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         acc_ff       <= '0;
         trail_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            acc_ff   <= step.acc;
            trail_ff <= step.trail_left;
         end
         if (advance && step.emit) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_byte_ff <= req_in_byte;
      end
      if (advance && step.emit) begin
         out_cp_ff <= step.acc;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_code_point = out_cp_ff;

endmodule
